FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module of this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define RESD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// a stalled transfer keeps its valid high and its payload unchanged
`define RESD_ASSERT_HOLD(label, vld, rdy, sig, msg) \
	`RESD_ASSERT(label, (vld && !rdy) |=> (vld && $stable(sig)), msg)

`endif

FILE: src/resd_pkg.sv
// ---------------------------------------------------------------------------
// resd_pkg
// Types and constants of the escape sequence decoder.
// ---------------------------------------------------------------------------
package resd_pkg;

	// field widths
	localparam int SYM_W   = 31;
	localparam int ACC_W   = 18;
	localparam int LEFT_W  = 3;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH) + 1;

	localparam logic [SYM_W-1:0] CH_BACKSLASH = SYM_W'(8'h5c);

	// decoder mode, one-hot
	typedef enum logic [3:0] {
		MODE_NORMAL = 4'b0001,
		MODE_ESC    = 4'b0010,
		MODE_HEX    = 4'b0100,
		MODE_OCT    = 4'b1000
	} mode_t;

	typedef struct packed {
		mode_t               mode;
		logic [ACC_W-1:0]    acc;
		logic [LEFT_W-1:0]   left;
	} dec_state_t;

	// one result item
	typedef struct packed {
		logic [SYM_W-1:0] decoded;
		logic             from_escape;
		logic             end_of_string;
	} res_t;

	// results of one symbol, r0 first
	typedef struct packed {
		res_t       r0;
		res_t       r1;
		logic [1:0] cnt;
	} dec_out_t;

	localparam dec_state_t STATE_RESET = '{mode: MODE_NORMAL, acc: '0, left: '0};

endpackage

FILE: src/resd_decode.sv
// ---------------------------------------------------------------------------
// resd_decode
// Next state and up to two results for one symbol, pure combinational.
// ---------------------------------------------------------------------------
module resd_decode import resd_pkg::*; (
	input  logic [SYM_W-1:0] symbol,
	input  logic             is_final,
	input  dec_state_t       state,
	output dec_state_t       next_state,
	output dec_out_t         out
);

	localparam logic [SYM_W-1:0] CH_LA = SYM_W'(8'h61);
	localparam logic [SYM_W-1:0] CH_LE = SYM_W'(8'h65);
	localparam logic [SYM_W-1:0] CH_LN = SYM_W'(8'h6e);
	localparam logic [SYM_W-1:0] CH_LR = SYM_W'(8'h72);
	localparam logic [SYM_W-1:0] CH_LF = SYM_W'(8'h66);
	localparam logic [SYM_W-1:0] CH_LT = SYM_W'(8'h74);
	localparam logic [SYM_W-1:0] CH_LU = SYM_W'(8'h75);
	localparam logic [SYM_W-1:0] CH_LX = SYM_W'(8'h78);
	localparam logic [SYM_W-1:0] CH_LO = SYM_W'(8'h6f);
	localparam logic [SYM_W-1:0] CH_0  = SYM_W'(8'h30);
	localparam logic [SYM_W-1:0] CH_7  = SYM_W'(8'h37);
	localparam logic [SYM_W-1:0] CH_8  = SYM_W'(8'h38);
	localparam logic [SYM_W-1:0] CH_9  = SYM_W'(8'h39);
	localparam logic [SYM_W-1:0] CH_UA = SYM_W'(8'h41);
	localparam logic [SYM_W-1:0] CH_UF = SYM_W'(8'h46);

	localparam logic [SYM_W-1:0] CODE_BEL = SYM_W'(8'h07);
	localparam logic [SYM_W-1:0] CODE_ESC = SYM_W'(8'h1b);
	localparam logic [SYM_W-1:0] CODE_LF  = SYM_W'(8'h0a);
	localparam logic [SYM_W-1:0] CODE_CR  = SYM_W'(8'h0d);
	localparam logic [SYM_W-1:0] CODE_FF  = SYM_W'(8'h0c);
	localparam logic [SYM_W-1:0] CODE_TAB = SYM_W'(8'h09);

	localparam logic [LEFT_W-1:0] LEFT_U   = LEFT_W'(4);
	localparam logic [LEFT_W-1:0] LEFT_X   = LEFT_W'(2);
	localparam logic [LEFT_W-1:0] LEFT_O   = LEFT_W'(6);
	localparam logic [LEFT_W-1:0] LEFT_OCT = LEFT_W'(2);

	typedef struct packed {
		logic             vld;
		logic [SYM_W-1:0] val;
		logic             esc;
	} put_t;

	function automatic put_t mk(input logic [SYM_W-1:0] val, input logic esc);
		put_t p;
		p.vld = 1'b1;
		p.val = val;
		p.esc = esc;
		return p;
	endfunction

	// digit value of the symbol, hex letters only in hex mode
	logic [3:0] dig_val;
	logic       dig_ok;

	always_comb begin
		dig_val = '0;
		dig_ok  = 1'b0;
		if (symbol >= CH_0 && symbol <= CH_7) begin
			dig_ok  = 1'b1;
			dig_val = {1'b0, symbol[2:0]};
		end else if (state.mode == MODE_HEX) begin
			if (symbol == CH_8 || symbol == CH_9) begin
				dig_ok  = 1'b1;
				dig_val = {3'b100, symbol[0]};
			end else if ((symbol >= CH_LA && symbol <= CH_LF) ||
				(symbol >= CH_UA && symbol <= CH_UF)) begin
				dig_ok  = 1'b1;
				dig_val = 4'(symbol[3:0] + 4'd9);
			end
		end
	end

	// mode step, then end-of-string flush, then packing of the results
	always_comb begin
		put_t              p0;
		put_t              p1;
		put_t              p2;
		logic [ACC_W-1:0]  acc_nx;
		logic [LEFT_W-1:0] left_nx;

		next_state = state;
		p0      = '0;
		p1      = '0;
		p2      = '0;
		acc_nx  = '0;
		left_nx = '0;

		unique case (state.mode)
			MODE_ESC: begin
				next_state.mode = MODE_NORMAL;
				unique case (symbol)
					CH_LA: p0 = mk(CODE_BEL, 1'b1);
					CH_LE: p0 = mk(CODE_ESC, 1'b1);
					CH_LN: p0 = mk(CODE_LF, 1'b1);
					CH_LR: p0 = mk(CODE_CR, 1'b1);
					CH_LF: p0 = mk(CODE_FF, 1'b1);
					CH_LT: p0 = mk(CODE_TAB, 1'b1);
					CH_LU: next_state = '{mode: MODE_HEX, acc: '0, left: LEFT_U};
					CH_LX: next_state = '{mode: MODE_HEX, acc: '0, left: LEFT_X};
					CH_LO: next_state = '{mode: MODE_OCT, acc: '0, left: LEFT_O};
					CH_8, CH_9: begin
						p0 = mk('0, 1'b1);
						p1 = mk(symbol, 1'b0);
					end
					default: begin
						if (symbol >= CH_0 && symbol <= CH_7) begin
							next_state = '{mode: MODE_OCT, acc: ACC_W'(symbol[2:0]),
								left: LEFT_OCT};
						end else begin
							p0 = mk(symbol, 1'b1);
						end
					end
				endcase
			end
			MODE_HEX, MODE_OCT: begin
				if (dig_ok && state.left != '0) begin
					acc_nx  = (state.mode == MODE_HEX) ? {state.acc[ACC_W-5:0], dig_val}
						: {state.acc[ACC_W-4:0], dig_val[2:0]};
					left_nx = state.left - 1'b1;
					if (left_nx == '0) begin
						p0         = mk(SYM_W'(acc_nx), 1'b1);
						next_state = STATE_RESET;
					end else begin
						next_state.acc  = acc_nx;
						next_state.left = left_nx;
					end
				end else begin
					// early stop: value out, symbol handled as normal
					p0         = mk(SYM_W'(state.acc), 1'b1);
					next_state = STATE_RESET;
					if (symbol == CH_BACKSLASH) begin
						next_state.mode = MODE_ESC;
					end else begin
						p1 = mk(symbol, 1'b0);
					end
				end
			end
			MODE_NORMAL: begin
				if (symbol == CH_BACKSLASH) begin
					next_state.mode = MODE_ESC;
				end else begin
					p1 = mk(symbol, 1'b0);
				end
			end
			default: next_state = STATE_RESET;
		endcase

		// flush a pending escape at the end of the string
		if (is_final) begin
			if (next_state.mode == MODE_ESC) begin
				p2 = mk(CH_BACKSLASH, 1'b1);
			end else if (next_state.mode == MODE_HEX || next_state.mode == MODE_OCT) begin
				p2 = mk(SYM_W'(next_state.acc), 1'b1);
			end
			next_state = STATE_RESET;
		end

		// at most two of the three are valid, keep their order
		out = '0;
		priority if (p0.vld) begin
			out.r0  = '{decoded: p0.val, from_escape: p0.esc, end_of_string: 1'b0};
			if (p1.vld) begin
				out.r1 = '{decoded: p1.val, from_escape: p1.esc, end_of_string: 1'b0};
			end else begin
				out.r1 = '{decoded: p2.val, from_escape: p2.esc, end_of_string: 1'b0};
			end
			out.cnt = (p1.vld || p2.vld) ? 2'd2 : 2'd1;
		end else if (p1.vld) begin
			out.r0  = '{decoded: p1.val, from_escape: p1.esc, end_of_string: 1'b0};
			out.r1  = '{decoded: p2.val, from_escape: p2.esc, end_of_string: 1'b0};
			out.cnt = p2.vld ? 2'd2 : 2'd1;
		end else begin
			out.r0  = '{decoded: p2.val, from_escape: p2.esc, end_of_string: 1'b0};
			out.cnt = p2.vld ? 2'd1 : 2'd0;
		end

		// end-of-string mark on the last result of a final symbol
		out.r0.end_of_string = is_final && (out.cnt == 2'd1);
		out.r1.end_of_string = is_final;
	end

endmodule

FILE: src/regex_escape_sequence_decoder_unit.sv
// ---------------------------------------------------------------------------
// regex_escape_sequence_decoder_unit
// Backslash escape decoder for a symbol stream, with a small result queue.
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata[30:0] symbol, tlast is_final
//  m_axis    out        tdata[30:0] decoded, tuser from_escape, tlast end_of_string
//
// One symbol is taken per cycle while s_axis_tready is high; it is decoded in the
// cycle after its transfer and its zero, one or two results go to a four-entry
// queue; a result passes the input register, then the queue. s_axis_tready falls
// when the queue and the symbol being decoded leave no room for two more results:
// a double result holds off input while a result is still queued; so do output
// stalls. arst_n clears the input valid, the decoder mode and the queue.
// ---------------------------------------------------------------------------
module regex_escape_sequence_decoder_unit import resd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [30:0] symbol, [31] zero
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [30:0] decoded, [31] zero
	output logic [0:0]  m_axis_tuser,   // [0] from_escape
	output logic        m_axis_tlast
);

	logic             valid_s1;
	logic [SYM_W-1:0] symbol_s1;
	logic             final_s1;

	dec_state_t       state_q;
	dec_state_t       state_nx;
	dec_out_t         dec_out;

	res_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic [1:0]       push_n;
	logic             in_xfer;
	logic             out_xfer;
	logic [PTR_W-1:0] wr_ptr_p1;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign push_n   = valid_s1 ? dec_out.cnt : 2'd0;

	// room for the item in flight and for two more results
	assign s_axis_tready = (count_q + CNT_W'(push_n)) <= CNT_W'(FIFO_DEPTH - 2);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			symbol_s1 <= s_axis_tdata[SYM_W-1:0];
			final_s1  <= s_axis_tlast;
		end
	end

	// decode pass
	resd_decode u_decode (
		.symbol     (symbol_s1),
		.is_final   (final_s1),
		.state      (state_q),
		.next_state (state_nx),
		.out        (dec_out)
	);

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (valid_s1) begin
			state_q <= state_nx;
		end
	end

	// result queue storage
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		for (int i = 0; i < FIFO_DEPTH; i++) begin
			if (push_n != 2'd0 && PTR_W'(i) == wr_ptr_q) begin
				fifo_q[i] <= dec_out.r0;
			end else if (push_n == 2'd2 && PTR_W'(i) == wr_ptr_p1) begin
				fifo_q[i] <= dec_out.r1;
			end
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (out_xfer) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(out_xfer);
		end
	end

	// output side
	assign m_axis_tvalid = count_q != '0;
	assign m_axis_tdata  = {1'b0, fifo_q[rd_ptr_q].decoded};
	assign m_axis_tuser  = fifo_q[rd_ptr_q].from_escape;
	assign m_axis_tlast  = fifo_q[rd_ptr_q].end_of_string;

endmodule

FILE: src/resd_checker.sv
// ---------------------------------------------------------------------------
// resd_checker
// Port-level checks of the escape decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module resd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// a stalled symbol stays offered unchanged
	`RESD_ASSERT_HOLD(a_in_hold, s_axis_tvalid, s_axis_tready, s_axis_tdata, "symbol changed while stalled")

	// a stalled result stays offered unchanged
	`RESD_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata, "result changed while stalled")
	`RESD_ASSERT_HOLD(a_out_hold_last, m_axis_tvalid, m_axis_tready, m_axis_tlast, "tlast changed while stalled")

	// an unescaped backslash never leaves the block
	`RESD_ASSERT(a_no_raw_bs, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[30:0] != 31'h5c), "raw backslash on output")

	// a string's last symbol always yields a result once registered and queued
	`RESD_ASSERT(a_final_result, (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> ##1 m_axis_tvalid, "no result after final symbol")

endmodule

bind regex_escape_sequence_decoder_unit resd_checker u_resd_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the escape sequence decoder against a cycle-free predictor. A short
// table of directed symbols goes first, some rows with typed-in results. It
// is followed by random strings built mostly from well-formed escapes with
// random content, mixed with noise and cut-off escapes. Sender gaps and
// receiver stalls change from phase to phase.
// ---------------------------------------------------------------------------
module testbench import resd_pkg::*; ();

	localparam int N_DIR           = 25;
	localparam int N_RAND          = 1450;
	localparam int TAIL_CYCLES     = 8;
	localparam int WATCHDOG_LIMIT  = 4000;

	// control codes of the letter escapes
	localparam logic [SYM_W-1:0] CC_BEL = 31'h07;
	localparam logic [SYM_W-1:0] CC_ESC = 31'h1b;
	localparam logic [SYM_W-1:0] CC_LF  = 31'h0a;
	localparam logic [SYM_W-1:0] CC_CR  = 31'h0d;
	localparam logic [SYM_W-1:0] CC_FF  = 31'h0c;
	localparam logic [SYM_W-1:0] CC_TAB = 31'h09;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_t;

	// one symbol to send; typed rows carry their own results
	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             last;
		logic             typed;
		logic [1:0]       n;
		res_t             r0;
		res_t             r1;
	} sym_row_t;

	localparam sym_row_t DIR_TAB [N_DIR] = '{
		'{31'h41,       1'b0, 1'b1, 2'd1, '{31'h41, 1'b0, 1'b0}, '0},        // plain
		'{31'h7fffffff, 1'b0, 1'b1, 2'd1, '{31'h7fffffff, 1'b0, 1'b0}, '0},  // largest
		'{31'h0,        1'b0, 1'b1, 2'd1, '{31'h0, 1'b0, 1'b0}, '0},         // zero
		'{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, '0, '0},
		'{31'h6e,       1'b0, 1'b1, 2'd1, '{CC_LF, 1'b1, 1'b0}, '0},         // \n
		'{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, '0, '0},
		'{31'h74,       1'b0, 1'b0, 2'd0, '0, '0},                           // \t
		'{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, '0, '0},
		'{31'h75,       1'b0, 1'b1, 2'd0, '0, '0},                           // \u
		'{31'h34,       1'b0, 1'b1, 2'd0, '0, '0},
		'{31'h31,       1'b0, 1'b1, 2'd0, '0, '0},
		'{31'h5a,       1'b0, 1'b0, 2'd0, '0, '0},                           // early stop
		'{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, '0, '0},
		'{31'h78,       1'b0, 1'b1, 2'd0, '0, '0},                           // \x
		'{31'h66,       1'b0, 1'b1, 2'd0, '0, '0},
		'{31'h46,       1'b0, 1'b0, 2'd0, '0, '0},                           // filled
		'{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, '0, '0},
		'{31'h6f,       1'b0, 1'b1, 2'd0, '0, '0},                           // \o
		'{31'h71,       1'b0, 1'b1, 2'd2, '{31'h0, 1'b1, 1'b0},              // no digits
			'{31'h71, 1'b0, 1'b0}},
		'{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, '0, '0},
		'{31'h38,       1'b0, 1'b1, 2'd2, '{31'h0, 1'b1, 1'b0},              // \8
			'{31'h38, 1'b0, 1'b0}},
		'{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, '0, '0},
		'{31'h31,       1'b0, 1'b1, 2'd0, '0, '0},                           // \1 octal
		'{31'h37,       1'b1, 1'b0, 2'd0, '0, '0},                           // flushed at end
		'{CH_BACKSLASH, 1'b1, 1'b1, 2'd1, '{CH_BACKSLASH, 1'b1, 1'b1}, '0}   // trailing
	};

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;   // [30:0] symbol, [31] zero
	logic        s_axis_tlast  = 1'b0; // is_final
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;         // [30:0] decoded, [31] zero
	logic [0:0]  m_axis_tuser;         // [0] from_escape
	logic        m_axis_tlast;         // end_of_string

	sym_row_t   symbol_q [$];
	res_t       decoded_exp_q [$];
	dec_state_t dec_st;
	res_t       pred_res [2];
	int         pred_n;
	int         sent_cnt     = 0;
	int         mismatch_cnt = 0;
	int         idle_cycles  = 0;
	bit         in_taken     = 1'b0;

	regex_escape_sequence_decoder_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------------
	function automatic void put_result(logic [SYM_W-1:0] val, logic esc);
		pred_res[pred_n] = '{decoded: val, from_escape: esc, end_of_string: 1'b0};
		pred_n++;
	endfunction

	// digit value in base 16 or 8, -1 when not a digit of that base
	function automatic int digit_of(logic [SYM_W-1:0] sym, bit hex);
		if (sym >= 31'h30 && sym <= 31'h37) return int'(sym - 31'h30);
		if (!hex) return -1;
		if (sym == 31'h38 || sym == 31'h39) return int'(sym - 31'h30);
		if (sym >= 31'h61 && sym <= 31'h66) return int'(sym - 31'h61) + 10;
		if (sym >= 31'h41 && sym <= 31'h46) return int'(sym - 31'h41) + 10;
		return -1;
	endfunction

	function automatic void plain_symbol(logic [SYM_W-1:0] sym);
		if (sym == CH_BACKSLASH)
			dec_st.mode = MODE_ESC;
		else
			put_result(sym, 1'b0);
	endfunction

	function automatic void open_numeric(mode_t m, logic [ACC_W-1:0] acc,
			logic [LEFT_W-1:0] left);
		dec_st.mode = m;
		dec_st.acc  = acc;
		dec_st.left = left;
	endfunction

	function automatic void decode_symbol(logic [SYM_W-1:0] sym, logic last);
		int v;
		bit hex;
		pred_n = 0;
		case (dec_st.mode)
			MODE_ESC: begin
				dec_st.mode = MODE_NORMAL;
				if (sym == 31'h61)      put_result(CC_BEL, 1'b1);
				else if (sym == 31'h65) put_result(CC_ESC, 1'b1);
				else if (sym == 31'h6e) put_result(CC_LF, 1'b1);
				else if (sym == 31'h72) put_result(CC_CR, 1'b1);
				else if (sym == 31'h66) put_result(CC_FF, 1'b1);
				else if (sym == 31'h74) put_result(CC_TAB, 1'b1);
				else if (sym == 31'h75) open_numeric(MODE_HEX, '0, 3'd4);
				else if (sym == 31'h78) open_numeric(MODE_HEX, '0, 3'd2);
				else if (sym == 31'h6f) open_numeric(MODE_OCT, '0, 3'd6);
				else if (sym >= 31'h30 && sym <= 31'h37)
					open_numeric(MODE_OCT, ACC_W'(sym - 31'h30), 3'd2);
				else if (sym == 31'h38 || sym == 31'h39) begin
					put_result('0, 1'b1);
					plain_symbol(sym);
				end else
					put_result(sym, 1'b1);
			end
			MODE_HEX, MODE_OCT: begin
				hex = (dec_st.mode == MODE_HEX);
				v   = digit_of(sym, hex);
				if (v >= 0 && dec_st.left != 0) begin
					if (hex)
						dec_st.acc = {dec_st.acc[ACC_W-5:0], 4'b0} | ACC_W'(v);
					else
						dec_st.acc = {dec_st.acc[ACC_W-4:0], 3'b0} | ACC_W'(v);
					dec_st.left = dec_st.left - 3'd1;
					if (dec_st.left == 0) begin
						put_result(SYM_W'(dec_st.acc), 1'b1);
						dec_st = STATE_RESET;
					end
				end else begin
					put_result(SYM_W'(dec_st.acc), 1'b1);
					dec_st = STATE_RESET;
					plain_symbol(sym);
				end
			end
			default: plain_symbol(sym);
		endcase

		// end of string flushes whatever escape is pending
		if (last) begin
			if (dec_st.mode == MODE_ESC)
				put_result(CH_BACKSLASH, 1'b1);
			else if (dec_st.mode == MODE_HEX || dec_st.mode == MODE_OCT)
				put_result(SYM_W'(dec_st.acc), 1'b1);
			dec_st = STATE_RESET;
			if (pred_n > 0) pred_res[pred_n-1].end_of_string = 1'b1;
		end
	endfunction

	// ---------------------------------------------------------------------
	// random strings
	// ---------------------------------------------------------------------
	function automatic void add_sym(logic [SYM_W-1:0] sym);
		sym_row_t row;
		row      = '0;
		row.sym  = sym;
		row.last = ($urandom_range(0, 24) == 0);
		symbol_q.push_back(row);
	endfunction

	function automatic logic [SYM_W-1:0] rand_printable();
		return SYM_W'($urandom_range(32, 126));
	endfunction

	function automatic logic [SYM_W-1:0] rand_hex_digit();
		int k;
		k = $urandom_range(0, 21);
		if (k < 10) return SYM_W'(31'h30 + k);
		if (k < 16) return SYM_W'(31'h61 + k - 10);
		return SYM_W'(31'h41 + k - 16);
	endfunction

	function automatic void add_string_piece();
		int kind;
		int nd;
		kind = $urandom_range(0, 99);
		if (kind < 25)
			add_sym(rand_printable());
		else if (kind < 35)
			add_sym(SYM_W'($urandom()));
		else if (kind < 50) begin
			add_sym(CH_BACKSLASH);
			case ($urandom_range(0, 5))
				0: add_sym(31'h61);
				1: add_sym(31'h65);
				2: add_sym(31'h6e);
				3: add_sym(31'h72);
				4: add_sym(31'h66);
				default: add_sym(31'h74);
			endcase
		end else if (kind < 58) begin
			add_sym(CH_BACKSLASH);
			add_sym($urandom_range(0, 1) ? rand_printable() : SYM_W'($urandom()));
		end else if (kind < 78) begin
			// \u or \x, sometimes short, sometimes overrun
			add_sym(CH_BACKSLASH);
			add_sym(kind < 70 ? 31'h75 : 31'h78);
			nd = $urandom_range(0, kind < 70 ? 5 : 3);
			repeat (nd) add_sym(rand_hex_digit());
			if ($urandom_range(0, 1)) add_sym(rand_printable());
		end else if (kind < 88) begin
			add_sym(CH_BACKSLASH);
			add_sym(31'h6f);
			nd = $urandom_range(0, 7);
			repeat (nd) add_sym(SYM_W'(31'h30 + $urandom_range(0, 7)));
			if ($urandom_range(0, 1)) add_sym(rand_printable());
		end else if (kind < 98) begin
			add_sym(CH_BACKSLASH);
			add_sym(SYM_W'(31'h30 + $urandom_range(0, 9)));
			nd = $urandom_range(0, 3);
			repeat (nd) add_sym(SYM_W'(31'h30 + $urandom_range(0, 9)));
		end else
			add_sym(CH_BACKSLASH);
		if ($urandom_range(0, 4) == 0) symbol_q[symbol_q.size()-1].last = 1'b1;
	endfunction

	// ---------------------------------------------------------------------
	// idling phases
	// ---------------------------------------------------------------------
	function automatic int phase_of(int idx);
		if (idx < N_DIR || idx >= symbol_q.size()) return -1;
		return ((idx - N_DIR) * 5) / (symbol_q.size() - N_DIR);
	endfunction

	function automatic idle_t idle_mode_at(int idx);
		case (phase_of(idx))
			1: return IDLE_SEND;
			2: return IDLE_RECV;
			3: return IDLE_BOTH;
			default: return IDLE_NONE;
		endcase
	endfunction

	// the sender waits for all results at the start of each random phase
	function automatic bit pause_point(int idx);
		if (idx == N_DIR) return 1'b1;
		return idx > N_DIR && phase_of(idx) != phase_of(idx - 1);
	endfunction

	// input driver, changes at the falling edge
	always @(negedge clk) begin
		idle_t im;
		bit    go;
		if (arst_n && !(s_axis_tvalid && !in_taken)) begin
			im = idle_mode_at(sent_cnt);
			go = sent_cnt < symbol_q.size()
				&& !(pause_point(sent_cnt) && decoded_exp_q.size() != 0);
			if (im == IDLE_SEND)
				go = go && ($urandom_range(0, 99) >= 75);
			else if (im == IDLE_BOTH)
				go = go && ($urandom_range(0, 99) >= 36);
			s_axis_tvalid <= go;
			if (go) begin
				s_axis_tdata <= {1'b0, symbol_q[sent_cnt].sym};
				s_axis_tlast <= symbol_q[sent_cnt].last;
			end
		end
	end

	// output back-pressure
	always @(negedge clk) begin
		idle_t im;
		im = idle_mode_at(sent_cnt);
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else if (im == IDLE_RECV)
			m_axis_tready <= ($urandom_range(0, 99) >= 75);
		else if (im == IDLE_BOTH)
			m_axis_tready <= ($urandom_range(0, 99) >= 36);
		else
			m_axis_tready <= 1'b1;
	end

	// transfer monitor: result check, then prediction for the accepted symbol
	always @(posedge clk) begin
		res_t     got;
		res_t     want;
		sym_row_t row;
		bit       out_taken;
		if (arst_n) begin
			in_taken  = s_axis_tvalid && s_axis_tready;
			out_taken = m_axis_tvalid && m_axis_tready;
			if (out_taken) begin
				got = '{decoded: m_axis_tdata[SYM_W-1:0], from_escape: m_axis_tuser[0],
					end_of_string: m_axis_tlast};
				if (decoded_exp_q.size() == 0) begin
					$error("unexpected result: decoded %h from_escape %b end_of_string %b",
						got.decoded, got.from_escape, got.end_of_string);
					mismatch_cnt++;
				end else begin
					want = decoded_exp_q.pop_front();
					if (got.decoded !== want.decoded) begin
						$error("decoded: expected %h, got %h", want.decoded, got.decoded);
						mismatch_cnt++;
					end
					if (got.from_escape !== want.from_escape) begin
						$error("from_escape: expected %b, got %b",
							want.from_escape, got.from_escape);
						mismatch_cnt++;
					end
					if (got.end_of_string !== want.end_of_string) begin
						$error("end_of_string: expected %b, got %b",
							want.end_of_string, got.end_of_string);
						mismatch_cnt++;
					end
				end
			end
			if (in_taken) begin
				row = symbol_q[sent_cnt];
				decode_symbol(row.sym, row.last);
				if (row.typed) begin
					if (row.n > 0) decoded_exp_q.push_back(row.r0);
					if (row.n > 1) decoded_exp_q.push_back(row.r1);
				end else
					for (int k = 0; k < pred_n; k++) decoded_exp_q.push_back(pred_res[k]);
				sent_cnt++;
			end
			if (in_taken || out_taken)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// stimulus build, reset and end of run
	initial begin
		dec_st = STATE_RESET;
		for (int i = 0; i < N_DIR; i++) symbol_q.push_back(DIR_TAB[i]);
		while (symbol_q.size() < N_DIR + N_RAND) add_string_piece();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (sent_cnt < symbol_q.size() || decoded_exp_q.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: regex_escape_sequence_decoder_unit.f
+incdir+src
src/resd_pkg.sv
src/resd_decode.sv
src/regex_escape_sequence_decoder_unit.sv
src/resd_checker.sv
tb/testbench.sv
